/* hdl/dva_pkg.sv */
// shared constants, types and helpers for the driver vigilance alarm
`default_nettype none

package dva_pkg;

  localparam int WEIGHT_WIDTH_DEF = 16;
  localparam int HOST_READS_W     = 5;
  localparam int COUNT_W          = 16;
  localparam int TENTHS_W         = 4;
  localparam int SECS_W           = 6;
  localparam int MINS_W           = 6;
  localparam int HOURS_W          = 5;
  localparam int PULSE_W          = 3;
  localparam int VOTE_W           = 3;

  localparam int TENTHS_PER_SEC = 10;
  localparam int SECS_PER_MIN   = 60;
  localparam int MINS_PER_HOUR  = 60;
  localparam int HOURS_PER_DAY  = 24;
  localparam int BLINK_ON_LAST  = 5;
  localparam int PULSE_ON_LAST  = 2;
  localparam int PULSE_WRAP     = 4;
  localparam int VOTE_MIN       = 3;

  localparam int BLINK_START_RST  = 50;
  localparam int ALARM_START_RST  = 150;
  localparam int WEIGHT_LIMIT_RST = 3840;
  localparam int TARE_DELAY_RST   = 5;

  typedef enum logic [1:0] {
    CFG_BLINK_START  = 2'd0,
    CFG_ALARM_START  = 2'd1,
    CFG_WEIGHT_LIMIT = 2'd2,
    CFG_TARE_DELAY   = 2'd3
  } cfg_reg_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

/* hdl/dva_if.sv */
// valid/ready channel interfaces for input items and results
`default_nettype none

interface dva_in_if #(
  parameter int WEIGHT_WIDTH = dva_pkg::WEIGHT_WIDTH_DEF
);
  import dva_pkg::*;

  logic                           valid;
  logic                           ready;
  logic                           tick;
  logic                           hand_present;
  logic signed [WEIGHT_WIDTH-1:0] raw_weight;
  logic                           toggle_press;
  logic [HOST_READS_W-1:0]        host_reads;

  modport source (
    output valid, tick, hand_present, raw_weight, toggle_press, host_reads,
    input  ready
  );
  modport sink (
    input  valid, tick, hand_present, raw_weight, toggle_press, host_reads,
    output ready
  );
endinterface

interface dva_out_if;
  import dva_pkg::*;

  logic               valid;
  logic               ready;
  logic               led_on;
  logic               vibrator_on;
  logic               buzzer_on;
  logic               load_active;
  logic [COUNT_W-1:0] load_seconds;
  logic [COUNT_W-1:0] absence_tenths;
  logic [HOURS_W-1:0] clock_hours;
  logic [MINS_W-1:0]  clock_minutes;
  logic [SECS_W-1:0]  clock_seconds;

  modport source (
    output valid, led_on, vibrator_on, buzzer_on, load_active, load_seconds,
           absence_tenths, clock_hours, clock_minutes, clock_seconds,
    input  ready
  );
  modport sink (
    input  valid, led_on, vibrator_on, buzzer_on, load_active, load_seconds,
           absence_tenths, clock_hours, clock_minutes, clock_seconds,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/driver_vigilance_alarm.sv */
// driver vigilance alarm: hand-on-wheel, seat load and host alarm monitor
//
//   channel   | direction | handshake            | contents
//   ----------+-----------+----------------------+-------------------------------
//   in_ch     | in        | valid/ready          | tick, hand, weight, toggle, reads
//   out_ch    | out       | valid/ready          | drive levels, counters, clock
//   cfg_*     | in        | write enable only    | register index and data
//
// one transaction per cycle sustained while out_ch is not stalled; each input
// transaction passes the input register, then the state and result register
// all state updates in one pass between the input and result registers
// rst_n is synchronous; configuration returns to its defaults on reset
// a stalled result holds both stages; the input register still takes one
// more transaction while the result waits
`default_nettype none

module driver_vigilance_alarm #(
  parameter int WEIGHT_WIDTH = dva_pkg::WEIGHT_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  dva_in_if.sink                     in_ch,
  dva_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire dva_pkg::cfg_reg_t     cfg_index,
  input  wire logic [((WEIGHT_WIDTH > dva_pkg::COUNT_W) ? WEIGHT_WIDTH
                      : dva_pkg::COUNT_W)-1:0] cfg_data
);
  import dva_pkg::*;

  localparam int NET_W  = WEIGHT_WIDTH + 2;
  localparam int ZERO_W = WEIGHT_WIDTH + 1;

  typedef struct packed {
    logic                           tick;
    logic                           hand_present;
    logic signed [WEIGHT_WIDTH-1:0] raw_weight;
    logic                           toggle_press;
    logic [HOST_READS_W-1:0]        host_reads;
  } in_item_t;

  // configuration
  logic [COUNT_W-1:0]             blink_start_r;
  logic [COUNT_W-1:0]             alarm_start_r;
  logic signed [WEIGHT_WIDTH-1:0] weight_limit_r;
  logic [SECS_W-1:0]              tare_delay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_start_r  <= COUNT_W'(BLINK_START_RST);
      alarm_start_r  <= COUNT_W'(ALARM_START_RST);
      weight_limit_r <= WEIGHT_WIDTH'(WEIGHT_LIMIT_RST);
      tare_delay_r   <= SECS_W'(TARE_DELAY_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLINK_START:  blink_start_r  <= cfg_data[COUNT_W-1:0];
        CFG_ALARM_START:  alarm_start_r  <= cfg_data[COUNT_W-1:0];
        CFG_WEIGHT_LIMIT: weight_limit_r <= cfg_data[WEIGHT_WIDTH-1:0];
        CFG_TARE_DELAY:   tare_delay_r   <= cfg_data[SECS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register and handshake
  logic     in_valid_r;
  in_item_t in_q_r;
  logic     out_valid_r;
  logic     adv;

  assign adv         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_valid_r <= in_ch.valid;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q_r.tick         <= in_ch.tick;
      in_q_r.hand_present <= in_ch.hand_present;
      in_q_r.raw_weight   <= in_ch.raw_weight;
      in_q_r.toggle_press <= in_ch.toggle_press;
      in_q_r.host_reads   <= in_ch.host_reads;
    end
  end

  // state, which also forms the result register
  logic [TENTHS_W-1:0]     tenths_r, tenths_nxt;
  logic [SECS_W-1:0]       secs_r, secs_nxt;
  logic [MINS_W-1:0]       mins_r, mins_nxt;
  logic [HOURS_W-1:0]      hours_r, hours_nxt;
  logic [COUNT_W-1:0]      absence_r, absence_nxt;
  logic                    absent_r, absent_nxt;
  logic [PULSE_W-1:0]      pulse_r, pulse_nxt;
  logic                    led_r, led_nxt;
  logic                    vib_r, vib_nxt;
  logic                    mon_r, mon_nxt;
  logic                    load_r, load_nxt;
  logic [COUNT_W-1:0]      load_cnt_r, load_cnt_nxt;
  logic                    tare_pending_r, tare_pending_nxt;
  logic signed [ZERO_W-1:0] zero_r, zero_nxt;
  logic signed [NET_W-1:0] net_r, net_nxt;
  logic                    buzzer_r, buzzer_nxt;
  logic signed [NET_W-1:0] limit_ext;
  logic [VOTE_W-1:0]       votes;

  assign limit_ext = NET_W'(weight_limit_r);

  always_comb begin
    tenths_nxt       = tenths_r;
    secs_nxt         = secs_r;
    mins_nxt         = mins_r;
    hours_nxt        = hours_r;
    absence_nxt      = absence_r;
    absent_nxt       = absent_r;
    pulse_nxt        = pulse_r;
    led_nxt          = led_r;
    vib_nxt          = vib_r;
    load_nxt         = load_r;
    load_cnt_nxt     = load_cnt_r;
    tare_pending_nxt = tare_pending_r;
    zero_nxt         = zero_r;

    mon_nxt = mon_r ^ in_q_r.toggle_press;

    // 100 ms tick and clock roll-over
    if (in_q_r.tick) begin
      absence_nxt = absent_r ? sat_inc(absence_r) : '0;
      if (tenths_r == TENTHS_W'(TENTHS_PER_SEC - 1)) begin
        tenths_nxt = '0;
        if (mon_nxt && (net_r > limit_ext)) begin
          load_nxt     = 1'b1;
          load_cnt_nxt = sat_inc(load_cnt_r);
        end else begin
          load_nxt     = 1'b0;
          load_cnt_nxt = '0;
        end
        if (secs_r == SECS_W'(SECS_PER_MIN - 1)) begin
          secs_nxt = '0;
          if (mins_r == MINS_W'(MINS_PER_HOUR - 1)) begin
            mins_nxt  = '0;
            hours_nxt = (hours_r == HOURS_W'(HOURS_PER_DAY - 1)) ? '0
                        : hours_r + HOURS_W'(1);
          end else begin
            mins_nxt = mins_r + MINS_W'(1);
          end
        end else begin
          secs_nxt = secs_r + SECS_W'(1);
        end
      end else begin
        tenths_nxt = tenths_r + TENTHS_W'(1);
      end
    end

    // one-time zero capture
    if (tare_pending_r && (secs_nxt > tare_delay_r)) begin
      zero_nxt         = net_r[ZERO_W-1:0];
      tare_pending_nxt = 1'b0;
    end

    net_nxt = NET_W'(in_q_r.raw_weight) - NET_W'(zero_nxt);

    // hand-absence warnings
    if (!in_q_r.hand_present) begin
      absent_nxt = 1'b1;
      if ((absence_nxt > blink_start_r) && (absence_nxt < alarm_start_r)) begin
        led_nxt = (tenths_nxt <= TENTHS_W'(BLINK_ON_LAST));
      end
      if (absence_nxt >= alarm_start_r) begin
        pulse_nxt = pulse_r + PULSE_W'(1);
        led_nxt   = (tenths_nxt <= TENTHS_W'(BLINK_ON_LAST));
        if (pulse_nxt <= PULSE_W'(PULSE_ON_LAST)) begin
          vib_nxt = 1'b1;
        end else if (pulse_nxt < PULSE_W'(PULSE_WRAP)) begin
          vib_nxt = 1'b0;
        end else begin
          pulse_nxt = '0;
        end
      end
    end else begin
      absence_nxt = '0;
      pulse_nxt   = '0;
      absent_nxt  = 1'b0;
      led_nxt     = 1'b0;
      vib_nxt     = 1'b0;
    end

    // 3-of-5 vote
    votes = VOTE_W'(in_q_r.host_reads[0]) + VOTE_W'(in_q_r.host_reads[1])
          + VOTE_W'(in_q_r.host_reads[2]) + VOTE_W'(in_q_r.host_reads[3])
          + VOTE_W'(in_q_r.host_reads[4]);
    buzzer_nxt = (votes >= VOTE_W'(VOTE_MIN));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tenths_r       <= '0;
      secs_r         <= '0;
      mins_r         <= '0;
      hours_r        <= '0;
      absence_r      <= '0;
      absent_r       <= 1'b0;
      pulse_r        <= '0;
      led_r          <= 1'b0;
      vib_r          <= 1'b0;
      mon_r          <= 1'b0;
      load_r         <= 1'b0;
      load_cnt_r     <= '0;
      tare_pending_r <= 1'b1;
      zero_r         <= '0;
      net_r          <= '0;
    end else if (adv) begin
      tenths_r       <= tenths_nxt;
      secs_r         <= secs_nxt;
      mins_r         <= mins_nxt;
      hours_r        <= hours_nxt;
      absence_r      <= absence_nxt;
      absent_r       <= absent_nxt;
      pulse_r        <= pulse_nxt;
      led_r          <= led_nxt;
      vib_r          <= vib_nxt;
      mon_r          <= mon_nxt;
      load_r         <= load_nxt;
      load_cnt_r     <= load_cnt_nxt;
      tare_pending_r <= tare_pending_nxt;
      zero_r         <= zero_nxt;
      net_r          <= net_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) buzzer_r <= buzzer_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.led_on         = led_r;
  assign out_ch.vibrator_on    = vib_r;
  assign out_ch.buzzer_on      = buzzer_r;
  assign out_ch.load_active    = load_r;
  assign out_ch.load_seconds   = load_cnt_r;
  assign out_ch.absence_tenths = absence_r;
  assign out_ch.clock_hours    = hours_r;
  assign out_ch.clock_minutes  = mins_r;
  assign out_ch.clock_seconds  = secs_r;

  // checks
  a_tenths_range: assert property (@(posedge clk) disable iff (!rst_n)
    tenths_r < TENTHS_W'(TENTHS_PER_SEC))
    else $error("tenths out of range");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_r < PULSE_W'(PULSE_WRAP))
    else $error("pulse count out of range");

  a_vib_needs_absence: assert property (@(posedge clk) disable iff (!rst_n)
    vib_r |-> absent_r)
    else $error("vibrator on with hand present");

  a_tare_once: assert property (@(posedge clk) disable iff (!rst_n)
    !tare_pending_r |=> !tare_pending_r)
    else $error("tare re-armed");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("transaction taken while both stages held");

endmodule

`default_nettype wire
